>>> src/rad_pkg.sv
// Shared types and codes for the restricted array deque.
`default_nettype none
package rad_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOINS  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_DENIED = 2'd3
  } status_e;

  typedef enum logic {
    MODE_IN_RESTRICTED  = 1'b0,
    MODE_OUT_RESTRICTED = 1'b1
  } mode_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_READ = 1'b1
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e cmd;
    logic denied;
  } item_t;

endpackage
`default_nettype wire

>>> src/rad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/rad_front.sv
// Front end: mode register, command classification and two-entry queue.
`default_nettype none
module rad_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_command,
  input  wire logic signed [31:0]    in_value,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output rad_pkg::item_t             q_item,
  output logic [DATA_WIDTH-1:0]      q_value
);
  import rad_pkg::*;

  mode_e                 mode_r;
  item_t                 item_r  [2];
  logic [DATA_WIDTH-1:0] value_r [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            count_r, count_nxt;
  logic                  push, pop;
  item_t                 item_in;
  cmd_e                  cmd_in;

  assign cmd_in = cmd_e'(in_command);

  always_comb begin
    item_in.cmd    = cmd_in;
    item_in.denied = ((cmd_in == CMD_PUSH_FRONT) && (mode_r == MODE_IN_RESTRICTED)) ||
                     ((cmd_in == CMD_POP_REAR)   && (mode_r == MODE_OUT_RESTRICTED));
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = item_r[rd_ptr_r];
  assign q_value  = value_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IN_RESTRICTED;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= mode_e'(cfg_wr_data);
      end
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wr_ptr_r]  <= item_in;
      value_r[wr_ptr_r] <= DATA_WIDTH'(in_value);
    end
  end

endmodule
`default_nettype wire

>>> src/rad_back.sv
// Back end: executes classified commands on the slot RAM and index registers.
`default_nettype none
module rad_back #(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire rad_pkg::item_t        q_item,
  input  wire logic [DATA_WIDTH-1:0] q_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic                       out_data_valid,
  output logic signed [31:0]         out_popped_data
);
  import rad_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  back_state_e    state_r, state_nxt;
  logic [IW-1:0]  front_r, front_nxt;
  logic [IW-1:0]  rear_r, rear_nxt;
  logic           empty_r, empty_nxt;
  logic           out_valid_r, out_valid_nxt;
  status_e        status_r, status_nxt;
  logic           dvalid_r, dvalid_nxt;
  logic [31:0]    popped_r, popped_nxt;

  logic                  take, pop_go;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign take = (state_r == B_IDLE) && q_valid && (!out_valid_r || out_ready);

  rad_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_go) begin
          state_nxt = B_READ;
        end
      end
      B_READ: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready       = take;
    pop_go        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = front_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    dvalid_nxt    = dvalid_r;
    popped_nxt    = popped_r;
    unique case (state_r)
      B_IDLE: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          dvalid_nxt    = 1'b0;
          popped_nxt    = '0;
          if (q_item.denied) begin
            status_nxt = ST_DENIED;
          end else begin
            unique case (q_item.cmd)
              CMD_PUSH_FRONT: begin
                if (empty_r) begin
                  ram_we    = 1'b1;
                  front_nxt = '0;
                  rear_nxt  = '0;
                  empty_nxt = 1'b0;
                end else if (front_r == '0) begin
                  status_nxt = ST_NOINS;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = front_r - 1'b1;
                  front_nxt = front_r - 1'b1;
                end
              end
              CMD_PUSH_REAR: begin
                if (empty_r) begin
                  ram_we    = 1'b1;
                  front_nxt = '0;
                  rear_nxt  = '0;
                  empty_nxt = 1'b0;
                end else if (rear_r == LAST) begin
                  status_nxt = ST_NOINS;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = rear_r + 1'b1;
                  rear_nxt  = rear_r + 1'b1;
                end
              end
              CMD_POP_FRONT, CMD_POP_REAR: begin
                if (empty_r) begin
                  status_nxt = ST_EMPTY;
                end else begin
                  // result is loaded once the read data returns
                  out_valid_nxt = 1'b0;
                  pop_go        = 1'b1;
                  ram_raddr     = (q_item.cmd == CMD_POP_FRONT) ? front_r : rear_r;
                  if (front_r == rear_r) begin
                    front_nxt = '0;
                    rear_nxt  = '0;
                    empty_nxt = 1'b1;
                  end else if (q_item.cmd == CMD_POP_FRONT) begin
                    front_nxt = front_r + 1'b1;
                  end else begin
                    rear_nxt = rear_r - 1'b1;
                  end
                end
              end
              default: status_nxt = ST_OK;
            endcase
          end
        end
      end
      B_READ: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        dvalid_nxt    = 1'b1;
        popped_nxt    = 32'(ram_rdata);
      end
      default: out_valid_nxt = out_valid_r && !out_ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    dvalid_r <= dvalid_nxt;
    popped_r <= popped_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data_valid  = dvalid_r;
  assign out_popped_data = popped_r;

endmodule
`default_nettype wire

>>> src/restricted_array_deque_core.sv
// Top level of the restricted array deque.
// Input channel: in_valid/in_ready carry one command word (in_command, in_value).
// Result channel: out_valid/out_ready carry one result word per command
// (out_status, out_data_valid, out_popped_data), in command order.
// cfg_wr_en/cfg_wr_data write the restrict mode (0 no push front, 1 no pop
// rear); write only while the block is idle.
// A push, reject or failed pop passes through the queue and the output
// register; a successful pop also passes through the slot RAM's registered
// read (state B_READ) between the two. Throughput: one word per cycle for
// pushes, rejects and failed pops while out_ready is high; after a
// successful pop the back end takes no new command until B_READ is over.
// A two-entry queue sits between the classifying front end and the
// executing back end; the result sits in an output register.
// Reset empties the deque, clears both indices and sets the mode to 0.
// Slot contents are not cleared. When out_ready is low the result holds,
// the back end stops and the queue fills, then in_ready drops.
`default_nettype none
module restricted_array_deque_core #(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic                    out_data_valid,
  output logic signed [31:0]      out_popped_data
);
  import rad_pkg::*;

  logic                  q_valid, q_ready;
  item_t                 q_item;
  logic [DATA_WIDTH-1:0] q_value;

  rad_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_value    (in_value),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .q_value     (q_value)
  );

  rad_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .q_value         (q_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_valid  (out_data_valid),
    .out_popped_data (out_popped_data)
  );

endmodule
`default_nettype wire
